>>> rtl/mlf_pkg.sv
// ----------------------------------------------------------------------------
// mlf_pkg: shared types and constants of the UART link framer
// Beat payloads, action and result codes, register indexes, key table.
// ----------------------------------------------------------------------------
`default_nettype none

package mlf_pkg;

  localparam int unsigned FRAME_BYTES = 4;
  localparam int unsigned NUM_KEYS    = 36;
  localparam logic [7:0]  HEAD_BYTE   = 8'hA5;

  // Input actions
  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_SEND = 2'd1,
    ACT_TICK = 2'd2
  } action_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_TX       = 3'd0,
    KIND_KEY      = 3'd1,
    KIND_OK       = 3'd2,
    KIND_TIMEOUT  = 3'd3,
    KIND_MISMATCH = 3'd4,
    KIND_UNKNOWN  = 3'd5
  } kind_e;

  // Configuration register indexes
  localparam logic [2:0] REG_ACK_LED_ON     = 3'd0;
  localparam logic [2:0] REG_ACK_LED_OFF    = 3'd1;
  localparam logic [2:0] REG_ACK_LCD_ONOFF  = 3'd2;
  localparam logic [2:0] REG_ACK_LED_ALL    = 3'd3;
  localparam logic [2:0] REG_ACK_LED_STATUS = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd5;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [7:0] cmd_code;
    logic [7:0] cmd_data;
  } req_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic [7:0] key_code;
    logic [7:0] key_value;
    logic [7:0] status;
    logic       last;
  } rsp_t;

  // Key code for frame commands 1..NUM_KEYS, zero elsewhere
  function automatic logic [7:0] key_map(input logic [7:0] cmd);
    logic [7:0] code;
    case (cmd)
      8'd1:  code = 8'd59;   8'd2:  code = 8'd60;   8'd3:  code = 8'd61;
      8'd4:  code = 8'd62;   8'd5:  code = 8'd63;   8'd6:  code = 8'd64;
      8'd7:  code = 8'd65;   8'd8:  code = 8'd66;   8'd9:  code = 8'd67;
      8'd10: code = 8'd68;   8'd11: code = 8'd87;   8'd12: code = 8'd88;
      8'd13: code = 8'd46;   8'd14: code = 8'd29;   8'd15: code = 8'd35;
      8'd16: code = 8'd19;   8'd17: code = 8'd25;   8'd18: code = 8'd2;
      8'd19: code = 8'd3;    8'd20: code = 8'd4;    8'd21: code = 8'd5;
      8'd22: code = 8'd6;    8'd23: code = 8'd7;    8'd24: code = 8'd8;
      8'd25: code = 8'd9;    8'd26: code = 8'd10;   8'd27: code = 8'd11;
      8'd28: code = 8'd55;   8'd29: code = 8'd98;   8'd30: code = 8'd103;
      8'd31: code = 8'd108;  8'd32: code = 8'd105;  8'd33: code = 8'd106;
      8'd34: code = 8'd96;   8'd35: code = 8'd78;   8'd36: code = 8'd74;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mlf_req_if.sv
// ----------------------------------------------------------------------------
// mlf_req_if: input channel of the UART link framer
// Valid/ready handshake carrying one action beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlf_req_if;
  logic          valid;
  logic          ready;
  mlf_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/mlf_rsp_if.sv
// ----------------------------------------------------------------------------
// mlf_rsp_if: result channel of the UART link framer
// Valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlf_rsp_if;
  logic          valid;
  logic          ready;
  mlf_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/mcu_uart_link_framer.sv
// ----------------------------------------------------------------------------
// mcu_uart_link_framer: both ends of a four-byte UART link
// Frames received bytes into a window, decodes key events and acknowledges,
// emits send frames and runs the acknowledge timeout on timer ticks.
// ----------------------------------------------------------------------------
// The first result beat is registered and valid in the cycle after the input beat.
// Bytes and ticks are taken at one input beat per cycle while the result channel
// keeps up; a send holds the result register until its four tx beats have left.
// A new input is taken in the cycle the final result beat leaves.
// Reset: control state and counters cleared, registers at their defaults;
// the frame window contents stay undefined until written.
`default_nettype none

module mcu_uart_link_framer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  mlf_req_if.sink         req_i,
  mlf_rsp_if.source       rsp_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_wdata_i
);

  // Configuration registers
  logic [7:0] ack_on_q, ack_off_q, ack_lcd_q, ack_all_q, ack_sts_code_q, timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_on_q       <= 8'd37;
      ack_off_q      <= 8'd38;
      ack_lcd_q      <= 8'd39;
      ack_all_q      <= 8'd40;
      ack_sts_code_q <= 8'd41;
      timeout_q      <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mlf_pkg::REG_ACK_LED_ON:     ack_on_q       <= cfg_wdata_i;
        mlf_pkg::REG_ACK_LED_OFF:    ack_off_q      <= cfg_wdata_i;
        mlf_pkg::REG_ACK_LCD_ONOFF:  ack_lcd_q      <= cfg_wdata_i;
        mlf_pkg::REG_ACK_LED_ALL:    ack_all_q      <= cfg_wdata_i;
        mlf_pkg::REG_ACK_LED_STATUS: ack_sts_code_q <= cfg_wdata_i;
        mlf_pkg::REG_TIMEOUT_TICKS:  timeout_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Link state
  logic [7:0] win_q [mlf_pkg::FRAME_BYTES];
  logic [7:0] win_d [mlf_pkg::FRAME_BYTES];
  logic [2:0] fill_q, fill_d;
  logic [7:0] ack_cmd_q, ack_cmd_d;
  logic [7:0] ack_val_q, ack_val_d;
  logic       wait_q, wait_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] pend_q, pend_d;

  // Result register and pending tx bytes of a send
  mlf_pkg::rsp_t res_q;
  logic [7:0]    txb_q [3];
  logic [2:0]    cnt_q;

  logic          accept, pop, push, push_send;
  mlf_pkg::rsp_t push_res;
  logic [7:0]    w1, w2, w3, sum3, tx_sum;
  logic          good, is_ack;

  assign req_i.ready = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = (cnt_q != 3'd0);
  assign rsp_o.data  = res_q;
  assign pop         = rsp_o.valid && rsp_o.ready;

  // Full-window view: older bytes from the window, newest from the beat
  assign w1     = win_q[1];
  assign w2     = win_q[2];
  assign w3     = req_i.data.rx_byte;
  assign sum3   = win_q[0] + w1 + w2;
  assign good   = (win_q[0] == mlf_pkg::HEAD_BYTE) && (sum3 == w3);
  assign is_ack = (w1 == ack_on_q) || (w1 == ack_off_q) || (w1 == ack_lcd_q) ||
                  (w1 == ack_all_q) || (w1 == ack_sts_code_q);
  assign tx_sum = mlf_pkg::HEAD_BYTE + req_i.data.cmd_code + req_i.data.cmd_data;

  // Next state and first result beat of the accepted item
  always_comb begin
    win_d     = win_q;
    fill_d    = fill_q;
    ack_cmd_d = ack_cmd_q;
    ack_val_d = ack_val_q;
    wait_d    = wait_q;
    tick_d    = tick_q;
    pend_d    = pend_q;
    push      = 1'b0;
    push_send = 1'b0;
    push_res  = '0;
    if (accept) begin
      case (req_i.data.action)
        mlf_pkg::ACT_BYTE: begin
          win_d[fill_q[1:0]] = req_i.data.rx_byte;
          fill_d             = fill_q + 3'd1;
          if (fill_q == 3'(mlf_pkg::FRAME_BYTES - 1)) begin
            if (good) begin
              fill_d = 3'd0;
              if ((w1 >= 8'd1) && (w1 <= 8'(mlf_pkg::NUM_KEYS))) begin
                push               = 1'b1;
                push_res.kind      = mlf_pkg::KIND_KEY;
                push_res.key_code  = mlf_pkg::key_map(w1);
                push_res.key_value = w2;
                push_res.last      = 1'b1;
              end else if (is_ack) begin
                ack_cmd_d = w1;
                ack_val_d = w2;
              end else begin
                ack_cmd_d     = 8'd0;
                ack_val_d     = 8'd0;
                push          = 1'b1;
                push_res.kind = mlf_pkg::KIND_UNKNOWN;
                push_res.last = 1'b1;
              end
            end else if (w1 == mlf_pkg::HEAD_BYTE) begin
              // resync to head at offset one
              win_d[0] = w1;
              win_d[1] = w2;
              win_d[2] = w3;
              fill_d   = 3'd3;
            end else if (w2 == mlf_pkg::HEAD_BYTE) begin
              win_d[0] = w2;
              win_d[1] = w3;
              fill_d   = 3'd2;
            end else if (w3 == mlf_pkg::HEAD_BYTE) begin
              win_d[0] = w3;
              fill_d   = 3'd1;
            end else begin
              fill_d = 3'd0;
            end
          end
        end
        mlf_pkg::ACT_SEND: begin
          ack_cmd_d        = 8'd0;
          ack_val_d        = 8'd0;
          pend_d           = req_i.data.cmd_code;
          tick_d           = 8'd0;
          wait_d           = 1'b1;
          push             = 1'b1;
          push_send        = 1'b1;
          push_res.kind    = mlf_pkg::KIND_TX;
          push_res.tx_byte = mlf_pkg::HEAD_BYTE;
        end
        mlf_pkg::ACT_TICK: begin
          if (wait_q) begin
            if (tick_q >= timeout_q) begin
              wait_d        = 1'b0;
              push          = 1'b1;
              push_res.kind = mlf_pkg::KIND_TIMEOUT;
              push_res.last = 1'b1;
            end else begin
              tick_d = tick_q + 8'd1;
              if ((ack_cmd_q != 8'd0) || (ack_val_q != 8'd0)) begin
                push          = 1'b1;
                push_res.last = 1'b1;
                if (ack_cmd_q == pend_q) begin
                  push_res.kind   = mlf_pkg::KIND_OK;
                  push_res.status = ack_val_q;
                end else begin
                  push_res.kind = mlf_pkg::KIND_MISMATCH;
                end
                ack_cmd_d = 8'd0;
                ack_val_d = 8'd0;
                wait_d    = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= 3'd0;
      ack_cmd_q <= 8'd0;
      ack_val_q <= 8'd0;
      wait_q    <= 1'b0;
      tick_q    <= 8'd0;
      pend_q    <= 8'd0;
    end else begin
      fill_q    <= fill_d;
      ack_cmd_q <= ack_cmd_d;
      ack_val_q <= ack_val_d;
      wait_q    <= wait_d;
      tick_q    <= tick_d;
      pend_q    <= pend_d;
    end
  end

  // Frame window, no reset
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // Result beat count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (push) begin
      cnt_q <= push_send ? 3'd4 : 3'd1;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  // Result payload and queued send bytes
  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q    <= push_res;
      txb_q[0] <= req_i.data.cmd_code;
      txb_q[1] <= req_i.data.cmd_data;
      txb_q[2] <= tx_sum;
    end else if (pop && (cnt_q > 3'd1)) begin
      res_q.tx_byte <= txb_q[0];
      res_q.last    <= (cnt_q == 3'd2);
      txb_q[0]      <= txb_q[1];
      txb_q[1]      <= txb_q[2];
    end
  end

  // Checks
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < 3'(mlf_pkg::FRAME_BYTES))
    else $error("frame window fill out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result beat count out of range");

  a_last_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.data.last == (cnt_q == 3'd1)))
    else $error("last flag out of step with beat count");

  a_send_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.data.action == mlf_pkg::ACT_SEND)) |=>
      (rsp_o.valid && (rsp_o.data.tx_byte == mlf_pkg::HEAD_BYTE) && wait_q))
    else $error("send did not start with head byte");

endmodule

`default_nettype wire

>>> tb/mcu_uart_link_framer_test.sv
// ----------------------------------------------------------------------------
// mcu_uart_link_framer_test: self-checking bench for the UART link framer
// Drives received bytes, send commands and timer ticks through the request
// channel, predicts every result beat from its own model of the framer and
// checks the result channel beat by beat, across several register settings
// and flow-control patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mcu_uart_link_framer_test;
  import mlf_pkg::*;

  // action code the framer must ignore
  localparam logic [1:0] ACT_IGNORED  = 2'd3;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 4;

  // keypad codes for frame commands 1..36, command 1 in the low byte
  localparam logic [36*8-1:0] KEYPAD_CODES = {
    8'd74, 8'd78, 8'd96, 8'd106, 8'd105, 8'd108, 8'd103, 8'd98, 8'd55,
    8'd11, 8'd10, 8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2,
    8'd25, 8'd19, 8'd35, 8'd29, 8'd46, 8'd88, 8'd87, 8'd68, 8'd67,
    8'd66, 8'd65, 8'd64, 8'd63, 8'd62, 8'd61, 8'd60, 8'd59
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [7:0] cfg_wdata;

  mlf_req_if req_if ();
  mlf_rsp_if rsp_if ();

  req_t pending_reqs[$];
  rsp_t expected_beats[$];

  int items_queued   = 0;
  int err_count      = 0;
  int idle_cycles    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // framer model state and register copy
  logic [7:0]  win_bytes [FRAME_BYTES];
  logic [2:0]  win_fill;
  logic [15:0] ack_latch;
  logic        await_ack;
  logic [7:0]  tick_cnt;
  logic [7:0]  sent_cmd;
  logic [7:0]  ack_codes [5];
  logic [7:0]  timeout_lim;

  mcu_uart_link_framer dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Framer model
  // --------------------------------------------------------------------------
  function automatic bit is_ack_code(input logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < 5; i++) if (ack_codes[i] == c) hit = 1'b1;
    return hit;
  endfunction

  task automatic push_beat(input kind_e k, input logic [7:0] tx, input logic [7:0] kc,
                           input logic [7:0] kv, input logic [7:0] st, input logic lst);
    rsp_t b;
    b.kind      = k;
    b.tx_byte   = tx;
    b.key_code  = kc;
    b.key_value = kv;
    b.status    = st;
    b.last      = lst;
    expected_beats.push_back(b);
  endtask

  // Update the model with one accepted request and queue the beats it causes
  task automatic predict_framer(input req_t r);
    logic [7:0] sum;
    logic [7:0] cmd;
    logic [7:0] dat;
    int         key_idx;
    int         head_pos;
    case (r.action)
      ACT_BYTE: begin
        if (win_fill >= FRAME_BYTES) win_fill = '0;
        win_bytes[win_fill] = r.rx_byte;
        win_fill++;
        if (win_fill == FRAME_BYTES) begin
          sum = win_bytes[0] + win_bytes[1] + win_bytes[2];
          if (win_bytes[0] == HEAD_BYTE && sum == win_bytes[3]) begin
            cmd = win_bytes[1];
            dat = win_bytes[2];
            if (cmd >= 8'd1 && cmd <= NUM_KEYS) begin
              key_idx = int'(cmd) - 1;
              push_beat(KIND_KEY, 8'd0, KEYPAD_CODES[key_idx*8 +: 8], dat, 8'd0, 1'b1);
            end else if (is_ack_code(cmd)) begin
              ack_latch = {dat, cmd};
            end else begin
              ack_latch = '0;
              push_beat(KIND_UNKNOWN, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
            end
            win_fill = '0;
          end else begin
            // bad frame: resync to the first later head byte, if any
            head_pos = 0;
            for (int i = FRAME_BYTES - 1; i >= 1; i--)
              if (win_bytes[i] == HEAD_BYTE) head_pos = i;
            if (head_pos != 0) begin
              for (int i = head_pos; i < FRAME_BYTES; i++)
                win_bytes[i - head_pos] = win_bytes[i];
              win_fill = 3'(FRAME_BYTES - head_pos);
            end else begin
              win_fill = '0;
            end
          end
        end
      end
      ACT_SEND: begin
        sum       = HEAD_BYTE + r.cmd_code + r.cmd_data;
        ack_latch = '0;
        sent_cmd  = r.cmd_code;
        tick_cnt  = '0;
        await_ack = 1'b1;
        push_beat(KIND_TX, HEAD_BYTE,  8'd0, 8'd0, 8'd0, 1'b0);
        push_beat(KIND_TX, r.cmd_code, 8'd0, 8'd0, 8'd0, 1'b0);
        push_beat(KIND_TX, r.cmd_data, 8'd0, 8'd0, 8'd0, 1'b0);
        push_beat(KIND_TX, sum,        8'd0, 8'd0, 8'd0, 1'b1);
      end
      ACT_TICK: begin
        if (await_ack) begin
          if (tick_cnt >= timeout_lim) begin
            await_ack = 1'b0;
            push_beat(KIND_TIMEOUT, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
          end else begin
            tick_cnt++;
            // a latch of all zeros means no answer yet
            if (ack_latch != '0) begin
              if (ack_latch[7:0] == sent_cmd)
                push_beat(KIND_OK, 8'd0, 8'd0, 8'd0, ack_latch[15:8], 1'b1);
              else
                push_beat(KIND_MISMATCH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
              ack_latch = '0;
              await_ack = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else begin
      if (req_if.valid && req_if.ready) predict_framer(req_if.data);
      // hold a stalled beat, otherwise offer the next one or idle
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid <= 1'b1;
          req_if.data  <= pending_reqs.pop_front();
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result backpressure
  always @(posedge clk) begin
    if (!rst_n) rsp_if.ready <= 1'b0;
    else        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : beat_monitor
    rsp_t want;
    rsp_t got;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (expected_beats.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: unexpected beat kind=%0d tx=%h key=%h val=%h st=%h last=%b",
                   $time, got.kind, got.tx_byte, got.key_code, got.key_value,
                   got.status, got.last);
      end else begin
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
            got.key_code !== want.key_code || got.key_value !== want.key_value ||
            got.status !== want.status || got.last !== want.last) begin
          err_count++;
          if (err_count <= 10) begin
            $display("%0t: mismatch exp kind=%0d tx=%h key=%h val=%h st=%h last=%b",
                     $time, want.kind, want.tx_byte, want.key_code, want.key_value,
                     want.status, want.last);
            $display("%0t:          got kind=%0d tx=%h key=%h val=%h st=%h last=%b",
                     $time, got.kind, got.tx_byte, got.key_code, got.key_value,
                     got.status, got.last);
          end
        end
      end
    end
  end

  // Watchdog: cycles with no beat moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 idle_cycles, expected_beats.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  task automatic queue_beat(input logic [1:0] act, input logic [7:0] rx,
                            input logic [7:0] cmd, input logic [7:0] dat);
    req_t r;
    r.action   = act;
    r.rx_byte  = rx;
    r.cmd_code = cmd;
    r.cmd_data = dat;
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    queue_beat(ACT_BYTE, b, rand_byte(), rand_byte());
  endtask

  task automatic queue_send(input logic [7:0] cmd, input logic [7:0] dat);
    queue_beat(ACT_SEND, rand_byte(), cmd, dat);
  endtask

  task automatic queue_tick();
    queue_beat(ACT_TICK, rand_byte(), rand_byte(), rand_byte());
  endtask

  // Four frame bytes; a spoiled frame has one byte flipped
  task automatic queue_frame(input logic [7:0] cmd, input logic [7:0] dat, input bit spoil);
    logic [7:0] fb [4];
    fb[0] = HEAD_BYTE;
    fb[1] = cmd;
    fb[2] = dat;
    fb[3] = HEAD_BYTE + cmd + dat;
    if (spoil) fb[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < 4; i++) queue_byte(fb[i]);
  endtask

  // Register write while idle; keeps the model copy in step
  task automatic set_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ACK_LED_ON:     ack_codes[0] = val;
      REG_ACK_LED_OFF:    ack_codes[1] = val;
      REG_ACK_LCD_ONOFF:  ack_codes[2] = val;
      REG_ACK_LED_ALL:    ack_codes[3] = val;
      REG_ACK_LED_STATUS: ack_codes[4] = val;
      REG_TIMEOUT_TICKS:  timeout_lim  = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic [7:0] c3,
                              input logic [7:0] c4, input logic [7:0] tmo);
    set_reg(REG_ACK_LED_ON, c0);
    set_reg(REG_ACK_LED_OFF, c1);
    set_reg(REG_ACK_LCD_ONOFF, c2);
    set_reg(REG_ACK_LED_ALL, c3);
    set_reg(REG_ACK_LED_STATUS, c4);
    set_reg(REG_TIMEOUT_TICKS, tmo);
    cfg_we <= 1'b0;
  endtask

  // Wait until every request is taken and every result has come back
  task automatic drain();
    while (pending_reqs.size() != 0 || req_if.valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly command/answer exchanges and key frames, plus line noise
  task automatic queue_traffic(input int n);
    int         stop_at;
    int         pick;
    int         hi;
    logic [7:0] cmd;
    logic [7:0] st;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        cmd = ($urandom_range(1) != 0) ? ack_codes[$urandom_range(4)] : rand_byte();
        queue_send(cmd, rand_byte());
        st = ($urandom_range(3) == 0) ? 8'd0 : rand_byte();
        case ($urandom_range(9))
          0, 1, 2, 3, 4: queue_frame(cmd, st, 1'b0);
          5, 6:          queue_frame(ack_codes[$urandom_range(4)], st, 1'b0);
          default: ;
        endcase
        hi = int'(timeout_lim) + 2;
        if (hi > 14) hi = 14;
        repeat ($urandom_range(1, hi)) queue_tick();
      end else if (pick < 55) begin
        cmd = ($urandom_range(4) != 0) ? 8'($urandom_range(1, NUM_KEYS)) : rand_byte();
        queue_frame(cmd, rand_byte(), 1'b0);
      end else if (pick < 65) begin
        queue_frame(rand_byte(), rand_byte(), 1'b0);
      end else if (pick < 80) begin
        queue_frame(rand_byte(),
                    ($urandom_range(2) == 0) ? HEAD_BYTE : rand_byte(), 1'b1);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3))
          queue_byte(($urandom_range(2) == 0) ? HEAD_BYTE : rand_byte());
      end else if (pick < 97) begin
        queue_tick();
      end else begin
        queue_beat(ACT_IGNORED, rand_byte(), rand_byte(), rand_byte());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= '0;
    cfg_wdata    <= '0;
    for (int i = 0; i < FRAME_BYTES; i++) win_bytes[i] = '0;
    for (int i = 0; i < 5; i++) ack_codes[i] = 8'(37 + i);
    win_fill    = '0;
    ack_latch   = '0;
    await_ack   = 1'b0;
    tick_cnt    = '0;
    sent_cmd    = '0;
    timeout_lim = 8'd10;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers, no idling: directed cases first
    queue_frame(8'd1, 8'd0, 1'b0);       // first key, release
    queue_frame(8'd36, 8'd255, 1'b0);    // last key, press
    queue_frame(8'd0, 8'h5A, 1'b0);      // command zero is unknown
    queue_send(8'd37, 8'd0);
    queue_frame(8'd37, 8'hC3, 1'b0);     // acknowledge latches, no beat
    queue_tick();                        // command ok with status
    queue_tick();                        // idle tick, nothing
    queue_beat(ACT_IGNORED, 8'hFF, 8'hFF, 8'hFF);
    queue_byte(8'h00);                   // stray byte forces a resync
    queue_frame(8'd255, HEAD_BYTE, 1'b0);
    queue_traffic(40);
    drain();

    // Shortest timeout, ack code zero, sender mostly idle
    apply_config(8'd0, 8'd255, rand_byte(), rand_byte(), rand_byte(), 8'd1);
    send_idle_pct  = 88;
    recv_stall_pct = 0;
    queue_send(8'd0, 8'h11);
    queue_frame(8'd0, 8'd0, 1'b0);       // all-zero latch reads as no answer
    queue_tick();
    queue_tick();                        // times out
    queue_traffic(40);
    drain();

    // Ack codes overlapping key range and head byte, receiver mostly stalled
    apply_config(8'd36, 8'd200, HEAD_BYTE, 8'd37, 8'd255, 8'd3);
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    queue_traffic(40);
    drain();

    // Longest timeout, both sides idling now and then
    apply_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), rand_byte(), 8'd255);
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    queue_traffic(15);
    queue_send(rand_byte(), rand_byte());
    repeat (257) queue_tick();           // count all the way to the timeout
    queue_traffic(15);
    drain();

    repeat (8) @(posedge clk);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
